FILE: rtl/mer_pkg.sv
// shared types and constants for the midpoint ellipse rasteriser
// microcode word layout, datapath status and point hand-off struct
// no dependencies
`default_nettype none

package mer_pkg;

    localparam int COORD_BITS = 12;
    localparam int SEMI_BITS  = COORD_BITS - 1;
    localparam int COLOR_BITS = 24;
    localparam int SQ_BITS    = 2 * SEMI_BITS;
    localparam int T_BITS     = 2 * (COORD_BITS + 1);
    localparam int MUL_BITS   = T_BITS + 1;
    localparam int DEC_BITS   = 48;
    localparam int UADDR_BITS = 5;

    localparam logic CMD_START = 1'b0;

    typedef logic [UADDR_BITS-1:0] t_uaddr;

    typedef enum logic [2:0] {
        MA_A, MA_B, MA_A2, MA_B2, MA_X2P1, MA_YM1
    } t_msel_a;

    typedef enum logic [3:0] {
        MB_A, MB_B, MB_ONE, MB_X, MB_Y, MB_T, MB_B2, MB_X2P3, MB_X2P2, MB_X2P1,
        MB_YM1, MB_TWO_M2Y, MB_THREE_M2Y
    } t_msel_b;

    typedef enum logic [2:0] {
        ACC_HOLD, ACC_ZERO_ADD, ACC_ZERO_SUB, ACC_ADD, ACC_SUB, ACC_DEC_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        J_NEXT, J_ALWAYS, J_ACC_NEG, J_D_NEG
    } t_jcond;

    typedef struct packed {
        t_msel_a msel_a;
        t_msel_b msel_b;
        t_acc_op acc_op;
        logic    acc_sh4;
        logic    ld_a2;
        logic    ld_b2;
        logic    ld_t;
        logic    ld_d;
        logic    set_r2;
        logic    mv_x;
        logic    mv_y;
        logic    commit;
        t_jcond  jcond;
        t_uaddr  jtarget;
    } t_uword;

    typedef struct packed {
        logic acc_neg;
        logic d_neg;
        logic in_r2;
        logic active;
    } t_dp_status;

    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] x;
        logic [SEMI_BITS-1:0]  y;
        logic [COLOR_BITS-1:0] color;
        logic                  done;
    } t_point;

endpackage

`default_nettype wire

FILE: rtl/mer_if.sv
// valid/ready channel interfaces for the ellipse rasteriser
// command items in, pixel items out; depends on mer_pkg
`default_nettype none

interface mer_in_if;
    import mer_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [COORD_BITS-1:0] corner_ax;
    logic [COORD_BITS-1:0] corner_ay;
    logic [COORD_BITS-1:0] corner_bx;
    logic [COORD_BITS-1:0] corner_by;
    logic [COLOR_BITS-1:0] fill_color;

    modport source (
        output valid, cmd, corner_ax, corner_ay, corner_bx, corner_by, fill_color,
        input  ready
    );
    modport sink (
        input  valid, cmd, corner_ax, corner_ay, corner_bx, corner_by, fill_color,
        output ready
    );
endinterface

interface mer_out_if;
    import mer_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_of_four;
    logic                  figure_done;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_of_four, figure_done,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_of_four, figure_done,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/midpoint_ellipse_rasterizer_top.sv
// midpoint ellipse rasteriser, one curve point per start item or active-figure step item
// start item sets up squares and first decision; region-one steps test the region first,
// the step into region two rebuilds the decision (one shared 27x27 multiplier, one
// microcode step per cycle, held on commit while the pixel stage is busy); each point
// sends 4 pixel items, one per cycle while ready, as the next command is worked on
// synchronous active-low reset: idle, no figure active, output empty
`default_nettype none

module midpoint_ellipse_rasterizer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mer_in_if.sink    i_in,
    mer_out_if.source o_out
);
    import mer_pkg::*;

    t_uword     ctl;
    t_dp_status status;
    t_point     point;
    logic       start_load;
    logic       out_free;

    mer_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_cmd     (i_in.cmd),
        .o_in_ready   (i_in.ready),
        .o_start_load (start_load),
        .i_status     (status),
        .i_out_free   (out_free),
        .o_ctl        (ctl)
    );

    mer_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_load (start_load),
        .i_ax         (i_in.corner_ax),
        .i_ay         (i_in.corner_ay),
        .i_bx         (i_in.corner_bx),
        .i_by         (i_in.corner_by),
        .i_color      (i_in.fill_color),
        .i_ctl        (ctl),
        .o_status     (status),
        .o_point      (point)
    );

    mer_pix_out u_pix_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ctl.commit),
        .i_point (point),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

FILE: rtl/mer_seq.sv
// microcode sequencer: step counter, control store and branch logic
// depends on mer_pkg
`default_nettype none

module mer_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_cmd,
    output logic                o_in_ready,
    output logic                o_start_load,
    input  mer_pkg::t_dp_status i_status,
    input  logic                i_out_free,
    output mer_pkg::t_uword     o_ctl
);
    import mer_pkg::*;

    // control store layout
    localparam t_uaddr UA_ST0    = t_uaddr'(0);
    localparam t_uaddr UA_ST1    = t_uaddr'(1);
    localparam t_uaddr UA_ST2    = t_uaddr'(2);
    localparam t_uaddr UA_ST3    = t_uaddr'(3);
    localparam t_uaddr UA_ST4    = t_uaddr'(4);
    localparam t_uaddr UA_ST5    = t_uaddr'(5);
    localparam t_uaddr UA_CHK0   = t_uaddr'(6);
    localparam t_uaddr UA_CHK1   = t_uaddr'(7);
    localparam t_uaddr UA_CHK2   = t_uaddr'(8);
    localparam t_uaddr UA_CHK3   = t_uaddr'(9);
    localparam t_uaddr UA_EN0    = t_uaddr'(10);
    localparam t_uaddr UA_EN1    = t_uaddr'(11);
    localparam t_uaddr UA_EN2    = t_uaddr'(12);
    localparam t_uaddr UA_EN3    = t_uaddr'(13);
    localparam t_uaddr UA_EN4    = t_uaddr'(14);
    localparam t_uaddr UA_EN5    = t_uaddr'(15);
    localparam t_uaddr UA_R2     = t_uaddr'(16);
    localparam t_uaddr UA_R2P0   = t_uaddr'(17);
    localparam t_uaddr UA_R2P1   = t_uaddr'(18);
    localparam t_uaddr UA_R2N0   = t_uaddr'(19);
    localparam t_uaddr UA_R2N1   = t_uaddr'(20);
    localparam t_uaddr UA_R2N2   = t_uaddr'(21);
    localparam t_uaddr UA_R1     = t_uaddr'(22);
    localparam t_uaddr UA_R1P0   = t_uaddr'(23);
    localparam t_uaddr UA_R1P1   = t_uaddr'(24);
    localparam t_uaddr UA_R1P2   = t_uaddr'(25);
    localparam t_uaddr UA_R1N0   = t_uaddr'(26);
    localparam t_uaddr UA_R1N1   = t_uaddr'(27);
    localparam t_uaddr UA_COMMIT = t_uaddr'(28);

    // multiplier issues every step, accumulator consumes last step's product
    function automatic t_uword urom(input t_uaddr addr);
        t_uword w;
        w = '0;
        case (addr)
            UA_ST0: begin
                w.msel_a = MA_A;   w.msel_b = MB_A;
            end
            UA_ST1: begin
                w.ld_a2 = 1'b1;
                w.msel_a = MA_B;   w.msel_b = MB_B;
            end
            UA_ST2: begin
                w.ld_b2 = 1'b1;
                w.msel_a = MA_A2;  w.msel_b = MB_B;
            end
            UA_ST3: begin
                w.acc_op = ACC_ZERO_SUB; w.acc_sh4 = 1'b1;
                w.msel_a = MA_B2;  w.msel_b = MB_ONE;
            end
            UA_ST4: begin
                w.acc_op = ACC_ADD; w.acc_sh4 = 1'b1;
                w.msel_a = MA_A2;  w.msel_b = MB_ONE;
            end
            UA_ST5: begin
                w.acc_op = ACC_ADD; w.ld_d = 1'b1;
                w.jcond = J_ALWAYS; w.jtarget = UA_COMMIT;
            end
            // region test: b2*x - a2*y
            UA_CHK0: begin
                w.msel_a = MA_B2;  w.msel_b = MB_X;
            end
            UA_CHK1: begin
                w.acc_op = ACC_ZERO_ADD;
                w.msel_a = MA_A2;  w.msel_b = MB_Y;
            end
            UA_CHK2: begin
                w.acc_op = ACC_SUB;
            end
            UA_CHK3: begin
                w.jcond = J_ACC_NEG; w.jtarget = UA_R1;
            end
            // entry to region two, decision rebuilt from scratch
            UA_EN0: begin
                w.set_r2 = 1'b1;
                w.msel_a = MA_X2P1; w.msel_b = MB_X2P1;
            end
            UA_EN1: begin
                w.ld_t = 1'b1;
                w.msel_a = MA_YM1;  w.msel_b = MB_YM1;
            end
            UA_EN2: begin
                w.ld_t = 1'b1;
                w.msel_a = MA_B2;   w.msel_b = MB_T;
            end
            UA_EN3: begin
                w.acc_op = ACC_ZERO_ADD;
                w.msel_a = MA_A2;   w.msel_b = MB_T;
            end
            UA_EN4: begin
                w.acc_op = ACC_ADD; w.acc_sh4 = 1'b1;
                w.msel_a = MA_A2;   w.msel_b = MB_B2;
            end
            UA_EN5: begin
                w.acc_op = ACC_SUB; w.acc_sh4 = 1'b1; w.ld_d = 1'b1;
            end
            UA_R2: begin
                w.jcond = J_D_NEG; w.jtarget = UA_R2N0;
            end
            UA_R2P0: begin
                w.msel_a = MA_A2;   w.msel_b = MB_THREE_M2Y;
            end
            UA_R2P1: begin
                w.acc_op = ACC_DEC_ADD; w.acc_sh4 = 1'b1; w.ld_d = 1'b1;
                w.mv_y = 1'b1;
                w.jcond = J_ALWAYS; w.jtarget = UA_COMMIT;
            end
            UA_R2N0: begin
                w.msel_a = MA_B2;   w.msel_b = MB_X2P2;
            end
            UA_R2N1: begin
                w.acc_op = ACC_DEC_ADD; w.acc_sh4 = 1'b1;
                w.msel_a = MA_A2;   w.msel_b = MB_THREE_M2Y;
            end
            UA_R2N2: begin
                w.acc_op = ACC_ADD; w.acc_sh4 = 1'b1; w.ld_d = 1'b1;
                w.mv_x = 1'b1; w.mv_y = 1'b1;
                w.jcond = J_ALWAYS; w.jtarget = UA_COMMIT;
            end
            UA_R1: begin
                w.jcond = J_D_NEG; w.jtarget = UA_R1N0;
            end
            UA_R1P0: begin
                w.msel_a = MA_B2;   w.msel_b = MB_X2P3;
            end
            UA_R1P1: begin
                w.acc_op = ACC_DEC_ADD; w.acc_sh4 = 1'b1;
                w.msel_a = MA_A2;   w.msel_b = MB_TWO_M2Y;
            end
            UA_R1P2: begin
                w.acc_op = ACC_ADD; w.acc_sh4 = 1'b1; w.ld_d = 1'b1;
                w.mv_x = 1'b1; w.mv_y = 1'b1;
                w.jcond = J_ALWAYS; w.jtarget = UA_COMMIT;
            end
            UA_R1N0: begin
                w.msel_a = MA_B2;   w.msel_b = MB_X2P3;
            end
            UA_R1N1: begin
                w.acc_op = ACC_DEC_ADD; w.acc_sh4 = 1'b1; w.ld_d = 1'b1;
                w.mv_x = 1'b1;
                w.jcond = J_ALWAYS; w.jtarget = UA_COMMIT;
            end
            UA_COMMIT: begin
                w.commit = 1'b1;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

    logic   r_busy, n_busy;
    t_uaddr r_upc, n_upc;
    t_uword word;
    logic   accept;

    assign word         = urom(r_upc);
    assign o_in_ready   = !r_busy;
    assign accept       = i_in_valid && !r_busy;
    assign o_start_load = accept && (i_in_cmd == CMD_START);

    always_comb begin
        n_busy = r_busy;
        n_upc  = r_upc;
        o_ctl  = '0;
        if (r_busy) begin
            o_ctl = word;
            if (word.commit) begin
                // hold on the commit step until the pixel stage is empty
                if (i_out_free) begin
                    n_busy = 1'b0;
                end else begin
                    o_ctl.commit = 1'b0;
                end
            end else begin
                case (word.jcond)
                    J_NEXT:    n_upc = r_upc + 1'b1;
                    J_ALWAYS:  n_upc = word.jtarget;
                    J_ACC_NEG: n_upc = i_status.acc_neg ? word.jtarget : r_upc + 1'b1;
                    J_D_NEG:   n_upc = i_status.d_neg ? word.jtarget : r_upc + 1'b1;
                    default:   n_upc = r_upc + 1'b1;
                endcase
            end
        end else if (accept) begin
            if (i_in_cmd == CMD_START) begin
                n_busy = 1'b1;
                n_upc  = UA_ST0;
            end else if (i_status.active) begin
                n_busy = 1'b1;
                n_upc  = i_status.in_r2 ? UA_R2 : UA_CHK0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= UA_ST0;
        end else begin
            r_busy <= n_busy;
            r_upc  <= n_upc;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mer_dpath.sv
// datapath: shared multiplier, decision accumulator and ellipse state
// driven one control word per cycle by mer_seq; depends on mer_pkg
`default_nettype none

module mer_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start_load,
    input  logic [mer_pkg::COORD_BITS-1:0] i_ax,
    input  logic [mer_pkg::COORD_BITS-1:0] i_ay,
    input  logic [mer_pkg::COORD_BITS-1:0] i_bx,
    input  logic [mer_pkg::COORD_BITS-1:0] i_by,
    input  logic [mer_pkg::COLOR_BITS-1:0] i_color,
    input  mer_pkg::t_uword                i_ctl,
    output mer_pkg::t_dp_status            o_status,
    output mer_pkg::t_point                o_point
);
    import mer_pkg::*;

    logic [COORD_BITS-1:0] dx, dy;
    logic [COORD_BITS:0]   sx, sy;
    logic [COORD_BITS-1:0] r_cx, r_cy, r_x;
    logic [SEMI_BITS-1:0]  r_a, r_b, r_y;
    logic [SQ_BITS-1:0]    r_a2, r_b2;
    logic [T_BITS-1:0]     r_t;
    logic [DEC_BITS-1:0]   r_p, r_acc, r_d, acc_term, n_acc;
    logic [MUL_BITS-1:0]   op_a, op_b, x_ext, y_ext;
    logic signed [2*MUL_BITS-1:0] mul_full;
    logic                  r_r2, r_active;
    logic [COLOR_BITS-1:0] r_color;

    assign dx = (i_ax >= i_bx) ? i_ax - i_bx : i_bx - i_ax;
    assign dy = (i_ay >= i_by) ? i_ay - i_by : i_by - i_ay;
    assign sx = {1'b0, i_ax} + {1'b0, i_bx};
    assign sy = {1'b0, i_ay} + {1'b0, i_by};

    assign x_ext = MUL_BITS'(r_x);
    assign y_ext = MUL_BITS'(r_y);

    always_comb begin
        case (i_ctl.msel_a)
            MA_A:    op_a = MUL_BITS'(r_a);
            MA_B:    op_a = MUL_BITS'(r_b);
            MA_A2:   op_a = MUL_BITS'(r_a2);
            MA_B2:   op_a = MUL_BITS'(r_b2);
            MA_X2P1: op_a = {x_ext[MUL_BITS-2:0], 1'b0} + MUL_BITS'(1);
            MA_YM1:  op_a = y_ext - MUL_BITS'(1);
            default: op_a = '0;
        endcase
    end

    // small signed factors wrap in MUL_BITS and are read as two's complement
    always_comb begin
        case (i_ctl.msel_b)
            MB_A:         op_b = MUL_BITS'(r_a);
            MB_B:         op_b = MUL_BITS'(r_b);
            MB_ONE:       op_b = MUL_BITS'(1);
            MB_X:         op_b = x_ext;
            MB_Y:         op_b = y_ext;
            MB_T:         op_b = MUL_BITS'(r_t);
            MB_B2:        op_b = MUL_BITS'(r_b2);
            MB_X2P3:      op_b = {x_ext[MUL_BITS-2:0], 1'b0} + MUL_BITS'(3);
            MB_X2P2:      op_b = {x_ext[MUL_BITS-2:0], 1'b0} + MUL_BITS'(2);
            MB_X2P1:      op_b = {x_ext[MUL_BITS-2:0], 1'b0} + MUL_BITS'(1);
            MB_YM1:       op_b = y_ext - MUL_BITS'(1);
            MB_TWO_M2Y:   op_b = MUL_BITS'(2) - {y_ext[MUL_BITS-2:0], 1'b0};
            MB_THREE_M2Y: op_b = MUL_BITS'(3) - {y_ext[MUL_BITS-2:0], 1'b0};
            default:      op_b = '0;
        endcase
    end

    assign mul_full = $signed(op_a) * $signed(op_b);

    assign acc_term = i_ctl.acc_sh4 ? {r_p[DEC_BITS-3:0], 2'b00} : r_p;

    always_comb begin
        case (i_ctl.acc_op)
            ACC_HOLD:     n_acc = r_acc;
            ACC_ZERO_ADD: n_acc = acc_term;
            ACC_ZERO_SUB: n_acc = '0 - acc_term;
            ACC_ADD:      n_acc = r_acc + acc_term;
            ACC_SUB:      n_acc = r_acc - acc_term;
            ACC_DEC_ADD:  n_acc = r_d + acc_term;
            default:      n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p   <= mul_full[DEC_BITS-1:0];
        r_acc <= n_acc;
        if (i_ctl.ld_d) begin
            r_d <= n_acc;
        end
        if (i_ctl.ld_a2) begin
            r_a2 <= r_p[SQ_BITS-1:0];
        end
        if (i_ctl.ld_b2) begin
            r_b2 <= r_p[SQ_BITS-1:0];
        end
        if (i_ctl.ld_t) begin
            r_t <= r_p[T_BITS-1:0];
        end
        if (i_start_load) begin
            r_a     <= dx[COORD_BITS-1:1];
            r_b     <= dy[COORD_BITS-1:1];
            r_cx    <= sx[COORD_BITS:1];
            r_cy    <= sy[COORD_BITS:1];
            r_color <= i_color;
            r_x     <= '0;
            r_y     <= dy[COORD_BITS-1:1];
        end else begin
            if (i_ctl.mv_x) begin
                r_x <= r_x + 1'b1;
            end
            if (i_ctl.mv_y) begin
                r_y <= r_y - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r2     <= 1'b0;
            r_active <= 1'b0;
        end else begin
            if (i_start_load) begin
                r_r2 <= 1'b0;
            end else if (i_ctl.set_r2) begin
                r_r2 <= 1'b1;
            end
            if (i_ctl.commit) begin
                r_active <= (r_y != '0);
            end
        end
    end

    assign o_status.acc_neg = r_acc[DEC_BITS-1];
    assign o_status.d_neg   = r_d[DEC_BITS-1];
    assign o_status.in_r2   = r_r2;
    assign o_status.active  = r_active;

    assign o_point.cx    = r_cx;
    assign o_point.cy    = r_cy;
    assign o_point.x     = r_x;
    assign o_point.y     = r_y;
    assign o_point.color = r_color;
    assign o_point.done  = (r_y == '0);

endmodule

`default_nettype wire

FILE: rtl/mer_pix_out.sv
// pixel stage: takes one point and sends its four mirrored pixels
// order (+x,+y) (-x,+y) (+x,-y) (-x,-y); depends on mer_pkg, mer_out_if
`default_nettype none

module mer_pix_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  mer_pkg::t_point i_point,
    output logic            o_free,
    mer_out_if.source       o_out
);
    import mer_pkg::*;

    localparam logic [1:0] IDX_PP   = 2'd0;
    localparam logic [1:0] IDX_MP   = 2'd1;
    localparam logic [1:0] IDX_PM   = 2'd2;
    localparam logic [1:0] IDX_LAST = 2'd3;

    logic                  r_valid;
    logic [1:0]            r_idx;
    logic [COORD_BITS-1:0] r_px_p, r_px_m, r_py_p, r_py_m;
    logic [COLOR_BITS-1:0] r_color;
    logic                  r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= IDX_PP;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= IDX_PP;
        end else if (r_valid && o_out.ready) begin
            if (r_idx == IDX_LAST) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 1'b1;
        end
    end

    // mirror sums formed once per point, coordinates wrap
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_px_p  <= i_point.cx + i_point.x;
            r_px_m  <= i_point.cx - i_point.x;
            r_py_p  <= i_point.cy + COORD_BITS'(i_point.y);
            r_py_m  <= i_point.cy - COORD_BITS'(i_point.y);
            r_color <= i_point.color;
            r_done  <= i_point.done;
        end
    end

    assign o_free = !r_valid;

    always_comb begin
        o_out.valid        = r_valid;
        o_out.pixel_color  = r_color;
        o_out.figure_done  = r_done;
        o_out.last_of_four = (r_idx == IDX_LAST);
        case (r_idx)
            IDX_PP: begin
                o_out.pixel_x = r_px_p;
                o_out.pixel_y = r_py_p;
            end
            IDX_MP: begin
                o_out.pixel_x = r_px_m;
                o_out.pixel_y = r_py_p;
            end
            IDX_PM: begin
                o_out.pixel_x = r_px_p;
                o_out.pixel_y = r_py_m;
            end
            default: begin
                o_out.pixel_x = r_px_m;
                o_out.pixel_y = r_py_m;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/mer_checker.sv
// port-level checks for the ellipse rasteriser, bound to the top level
// depends on mer_pkg and midpoint_ellipse_rasterizer_top
`default_nettype none

module mer_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_in_cmd,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [mer_pkg::COORD_BITS-1:0] i_pixel_x,
    input logic [mer_pkg::COORD_BITS-1:0] i_pixel_y,
    input logic [mer_pkg::COLOR_BITS-1:0] i_pixel_color,
    input logic                           i_last_of_four,
    input logic                           i_figure_done
);
    import mer_pkg::*;

    // output stage is empty straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("pixel item offered after reset");

    // a start always keeps the sequencer busy for the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_cmd == CMD_START) |=> !i_in_ready)
        else $error("command taken straight after a start item");

    // the four pixels of a point come as one burst with one colour and done flag
    a_four_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last_of_four)
        |=> (i_out_valid && $stable(i_pixel_color) && $stable(i_figure_done)))
        else $error("mirrored pixel burst broken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> (i_out_valid && $stable(i_pixel_x) && $stable(i_pixel_y)
             && $stable(i_last_of_four)))
        else $error("stalled pixel item changed");

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker u_mer_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_cmd       (i_in.cmd),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_pixel_x      (o_out.pixel_x),
    .i_pixel_y      (o_out.pixel_y),
    .i_pixel_color  (o_out.pixel_color),
    .i_last_of_four (o_out.last_of_four),
    .i_figure_done  (o_out.figure_done)
);

`default_nettype wire
